@@ hw/rtl/assert_macros.svh @@
// Assertion helpers: clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ hw/rtl/stw_pkg.sv @@
package stw_pkg;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_FIRST = 8'h20;
    localparam logic [7:0] CH_LAST  = 8'h7E;

    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_GLYPH = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] byte_in;
        logic [2:0] read_row;
        logic [4:0] read_col;
    } req_t;

    typedef struct packed {
        kind_t      result_kind;
        logic       scrolled;
        logic [2:0] cell_row;
        logic [4:0] cell_col;
        logic [6:0] cell_char;
    } res_t;

endpackage

@@ hw/rtl/stw_store.sv @@
module stw_store #(
    parameter int ROWS = 8,
    parameter int COLS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            ch_we,
    input  logic [$clog2(ROWS*COLS)-1:0]    ch_waddr,
    input  logic [6:0]                      ch_wdata,
    input  logic                            len_we,
    input  logic [$clog2(ROWS)-1:0]         len_waddr,
    input  logic [$clog2(COLS+1)-1:0]       len_wdata,
    input  logic                            len_clr,
    input  logic [$clog2(ROWS)-1:0]         len_caddr,
    input  logic                            rd_en,
    input  logic [$clog2(ROWS*COLS)-1:0]    ch_raddr,
    input  logic [$clog2(ROWS)-1:0]         len_raddr,
    output logic [6:0]                      ch_q,
    output logic [$clog2(COLS+1)-1:0]       len_q
);

    localparam int DEPTH = ROWS * COLS;
    localparam int LW    = $clog2(COLS + 1);

    logic [6:0]    ch_mem [DEPTH];
    logic [LW-1:0] len_mem [ROWS];
    logic [ROWS-1:0] vld_reg;
    logic [6:0]    ch_q_reg;
    logic [LW-1:0] len_q_reg;
    logic          vld_q_reg;

    always_ff @(posedge clk)
    begin
        if (ch_we)
        begin
            ch_mem[ch_waddr] <= ch_wdata;
        end
        if (rd_en)
        begin
            ch_q_reg <= ch_mem[ch_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_waddr] <= len_wdata;
        end
        if (rd_en)
        begin
            len_q_reg <= len_mem[len_raddr];
        end
    end

    // a row without its valid bit has length zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (len_we)
            begin
                vld_reg[len_waddr] <= 1'b1;
            end
            if (len_clr)
            begin
                vld_reg[len_caddr] <= 1'b0;
            end
            if (rd_en)
            begin
                vld_q_reg <= vld_reg[len_raddr];
            end
        end
    end

    assign ch_q  = ch_q_reg;
    assign len_q = vld_q_reg ? len_q_reg : '0;

endmodule

@@ hw/rtl/scrolling_text_window.sv @@
// Text window of ROWS x COLS cells kept as a ring of rows in one character
// RAM plus a row-length RAM. One word is taken per cycle while cfg_we is low
// (busy stays low); its result shows on result in the next cycle with done
// high, as the RAM reads and result fields are registered. Results cannot be
// held off. Scrolling moves the ring base only, so it holds off no word. Row
// lengths are zero after reset through per-row valid flops; no clearing pass
// runs. A cfg_we write homes the cursor to column 0 of row cfg_data.
module scrolling_text_window
    import stw_pkg::*;
#(
    parameter int ROWS = 8,
    parameter int COLS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  req_t       req,
    input  logic       cfg_we,
    input  logic [2:0] cfg_data,
    output logic       done,
    output res_t       result
);

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLS);
    localparam int LW = $clog2(COLS + 1);
    localparam int AW = $clog2(ROWS * COLS);
    localparam int RW1 = RW + 1;
    localparam logic [RW:0]   ROWS_V   = RW1'(ROWS);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);
    localparam logic [AW-1:0] COLS_A   = AW'(COLS);

    function automatic logic [RW-1:0] phys(input logic [RW-1:0] b, input logic [RW-1:0] l);
        logic [RW:0] s;
        s = {1'b0, b} + {1'b0, l};
        if (s >= ROWS_V)
        begin
            s = s - ROWS_V;
        end
        return s[RW-1:0];
    endfunction

    logic [RW-1:0] base_reg, base_next;
    logic [RW-1:0] crow_reg, crow_next;
    logic [CW-1:0] ccol_reg, ccol_next;
    logic          done_reg;
    kind_t         kind_reg, kind_next;
    logic          scr_reg, scr_next;
    logic [2:0]    row_reg, row_next;
    logic [4:0]    col_reg, col_next;
    logic [6:0]    pch_reg, pch_next;
    logic          hit_reg, hit_next;
    logic [CW-1:0] rcol_reg, rcol_next;

    logic          accept;
    logic [RW-1:0] p_cur, p_rd, r_l;
    logic [CW-1:0] c_l;
    logic          is_eol, is_glyph;
    logic          ch_we, len_we, len_clr, rd_en;
    logic [AW-1:0] ch_waddr, ch_raddr;
    logic [LW-1:0] len_wdata;
    logic [6:0]    ch_q;
    logic [LW-1:0] len_q;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign p_cur    = phys(base_reg, crow_reg);
    assign r_l      = RW'(req.read_row);
    assign c_l      = CW'(req.read_col);
    assign p_rd     = phys(base_reg, r_l);
    assign is_eol   = (req.byte_in == CH_LF) || (req.byte_in == CH_CR);
    assign is_glyph = (req.byte_in >= CH_FIRST) && (req.byte_in <= CH_LAST);

    always_comb
    begin
        base_next = base_reg;
        crow_next = crow_reg;
        ccol_next = ccol_reg;
        kind_next = KIND_NONE;
        scr_next  = 1'b0;
        row_next  = '0;
        col_next  = '0;
        pch_next  = '0;
        hit_next  = 1'b0;
        rcol_next = c_l;
        ch_we     = 1'b0;
        len_we    = 1'b0;
        len_clr   = 1'b0;
        rd_en     = 1'b0;
        ch_waddr  = AW'(p_cur) * COLS_A + AW'(ccol_reg);
        len_wdata = LW'(ccol_reg);
        hit_next  = (32'(req.read_row) < ROWS) && (32'(req.read_col) < COLS);
        ch_raddr  = hit_next ? (AW'(p_rd) * COLS_A + AW'(c_l)) : '0;
        if (cfg_we)
        begin
            crow_next = (32'(cfg_data) >= ROWS) ? LAST_ROW : RW'(cfg_data);
            ccol_next = '0;
        end
        else if (accept)
        begin
            if (req.req_type == REQ_READ)
            begin
                rd_en     = 1'b1;
                kind_next = KIND_READ;
                row_next  = req.read_row;
                col_next  = req.read_col;
            end
            else if (is_eol || is_glyph)
            begin
                len_we = 1'b1;
                if (is_glyph)
                begin
                    ch_we     = 1'b1;
                    len_wdata = LW'(ccol_reg) + LW'(1);
                    kind_next = KIND_GLYPH;
                    row_next  = 3'(crow_reg);
                    col_next  = 5'(ccol_reg);
                    pch_next  = req.byte_in[6:0];
                    ccol_next = ccol_reg + CW'(1);
                end
                if (is_eol || (ccol_reg == LAST_COL))
                begin
                    ccol_next = '0;
                    if (crow_reg == LAST_ROW)
                    begin
                        // new bottom row is the old base row
                        len_clr   = 1'b1;
                        base_next = (base_reg == LAST_ROW) ? '0 : base_reg + RW'(1);
                        scr_next  = 1'b1;
                    end
                    else
                    begin
                        crow_next = crow_reg + RW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            crow_reg <= RW'(1);
            ccol_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            base_reg <= base_next;
            crow_reg <= crow_next;
            ccol_reg <= ccol_next;
            done_reg <= accept && !cfg_we;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        scr_reg  <= scr_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        pch_reg  <= pch_next;
        hit_reg  <= hit_next;
        rcol_reg <= rcol_next;
    end

    stw_store #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ch_we    (ch_we),
        .ch_waddr (ch_waddr),
        .ch_wdata (req.byte_in[6:0]),
        .len_we   (len_we),
        .len_waddr(p_cur),
        .len_wdata(len_wdata),
        .len_clr  (len_clr),
        .len_caddr(base_reg),
        .rd_en    (rd_en),
        .ch_raddr (ch_raddr),
        .len_raddr(p_rd),
        .ch_q     (ch_q),
        .len_q    (len_q)
    );

    always_comb
    begin
        result.result_kind = kind_reg;
        result.scrolled    = scr_reg;
        result.cell_row    = row_reg;
        result.cell_col    = col_reg;
        result.cell_char   = pch_reg;
        if (kind_reg == KIND_READ)
        begin
            result.cell_char = (hit_reg && (LW'(rcol_reg) < len_q)) ? ch_q : '0;
        end
    end

    assign done = done_reg;

endmodule

@@ hw/rtl/stw_checker.sv @@
`include "assert_macros.svh"

module stw_checker
    import stw_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       cfg_we,
    input logic       done,
    input res_t       result
);

    logic fields_clear;
    assign fields_clear = (result.cell_row == 3'd0) && (result.cell_col == 5'd0)
        && (result.cell_char == 7'd0);

    `ASSERT_NEXT(a_word_done, start && !busy && !cfg_we, done)
    `ASSERT_NEXT(a_no_spurious, !(start && !busy), !done)
    `ASSERT_SAME(a_read_no_scroll, done && result.result_kind == KIND_READ, !result.scrolled)
    `ASSERT_SAME(a_none_zero, done && result.result_kind == KIND_NONE, fields_clear)

endmodule

bind scrolling_text_window stw_checker u_stw_checker (.*);
